// File: sv/vcsp_pkg.sv
package vcsp_pkg;

    localparam int PALETTE_ENTRIES = 256;

    // output queue: room for the two records one byte can cause, plus slack
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_SIZE    = 2'd0;
    localparam logic [1:0] KIND_VOXEL   = 2'd1;
    localparam logic [1:0] KIND_PALETTE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAIN  = 3'd2;
    localparam logic [2:0] STATUS_NO_SIZE   = 3'd3;
    localparam logic [2:0] STATUS_NO_VOXELS = 3'd4;

    // little-endian tags as they appear once four bytes are gathered
    localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
    localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
    localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
    localparam logic [31:0] TAG_XYZI = 32'h495A_5958;
    localparam logic [31:0] TAG_RGBA = 32'h4142_4752;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic signed [31:0] extent_x;
        logic signed [31:0] extent_y;
        logic signed [31:0] extent_z;
        logic [7:0]         voxel_x;
        logic [7:0]         voxel_y;
        logic [7:0]         voxel_z;
        logic [7:0]         color_slot;
        logic [7:0]         palette_index;
        logic [31:0]        rgba_word;
        logic [2:0]         status;
    } t_record;

    typedef struct packed {
        logic data_push;
        logic done_push;
    } t_push;

endpackage

// File: sv/voxel_chunk_stream_parser_unit.sv
// Channel   Direction  Handshake                 Payload
// byte in   input      i_in_valid / o_in_ready   i_data_byte, i_end_of_file
// record    output     o_out_valid / i_out_ready o_record_kind .. o_status
//
// One byte is taken per cycle; its records reach the output queue at the next edge.
// The final byte of a file can cause two records, which drain one per cycle while i_out_ready is high.
// Input stalls only while the four-entry output queue lacks room for two records.
// Synchronous active-low reset empties the queue and returns the parser to the magic.
module voxel_chunk_stream_parser_unit #(
    parameter int PALETTE_ENTRIES = vcsp_pkg::PALETTE_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_file,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_record_kind,
    output logic signed [31:0] o_extent_x,
    output logic signed [31:0] o_extent_y,
    output logic signed [31:0] o_extent_z,
    output logic [7:0]         o_voxel_x,
    output logic [7:0]         o_voxel_y,
    output logic [7:0]         o_voxel_z,
    output logic [7:0]         o_color_slot,
    output logic [7:0]         o_palette_index,
    output logic [31:0]        o_rgba_word,
    output logic [2:0]         o_status
);

    vcsp_pkg::t_push   push;
    vcsp_pkg::t_record data_rec;
    vcsp_pkg::t_record done_rec;
    vcsp_pkg::t_record head;
    logic              take;

    assign take = i_in_valid && o_in_ready;

    vcsp_parse #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (push),
        .o_data_rec    (data_rec),
        .o_done_rec    (done_rec)
    );

    vcsp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data_rec (data_rec),
        .i_done_rec (done_rec),
        .o_room     (o_in_ready),
        .o_valid    (o_out_valid),
        .i_pop      (i_out_ready),
        .o_head     (head)
    );

    assign o_record_kind   = head.record_kind;
    assign o_extent_x      = head.extent_x;
    assign o_extent_y      = head.extent_y;
    assign o_extent_z      = head.extent_z;
    assign o_voxel_x       = head.voxel_x;
    assign o_voxel_y       = head.voxel_y;
    assign o_voxel_z       = head.voxel_z;
    assign o_color_slot    = head.color_slot;
    assign o_palette_index = head.palette_index;
    assign o_rgba_word     = head.rgba_word;
    assign o_status        = head.status;

    a_eof_gives_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_file |=> o_out_valid)
        else $error("final byte left no record");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind != vcsp_pkg::KIND_DONE |-> o_status == vcsp_pkg::STATUS_OK)
        else $error("status set on a data record");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == vcsp_pkg::KIND_DONE
            |-> o_status <= vcsp_pkg::STATUS_NO_VOXELS)
        else $error("status code out of range");

endmodule

// File: sv/vcsp_parse.sv
module vcsp_parse #(
    parameter int PALETTE_ENTRIES = vcsp_pkg::PALETTE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output vcsp_pkg::t_push   o_push,
    output vcsp_pkg::t_record o_data_rec,
    output vcsp_pkg::t_record o_done_rec
);

    localparam int PAL_W = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [PAL_W-1:0] PAL_LAST = PAL_W'(PALETTE_ENTRIES);

    typedef enum logic [13:0] {
        PH_MAGIC         = 14'b00_0000_0000_0001,
        PH_VERSION       = 14'b00_0000_0000_0010,
        PH_MAIN_TAG      = 14'b00_0000_0000_0100,
        PH_MAIN_CONTENT  = 14'b00_0000_0000_1000,
        PH_MAIN_CHILDREN = 14'b00_0000_0001_0000,
        PH_CHUNK_TAG     = 14'b00_0000_0010_0000,
        PH_CHUNK_CSIZE   = 14'b00_0000_0100_0000,
        PH_CHUNK_KSIZE   = 14'b00_0000_1000_0000,
        PH_SIZE_DATA     = 14'b00_0001_0000_0000,
        PH_XYZI_COUNT    = 14'b00_0010_0000_0000,
        PH_XYZI_ENTRIES  = 14'b00_0100_0000_0000,
        PH_RGBA          = 14'b00_1000_0000_0000,
        PH_SKIP          = 14'b01_0000_0000_0000,
        PH_HALT          = 14'b10_0000_0000_0000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_byte_pos, n_byte_pos;
    logic [31:0]        r_word, n_word;
    logic [31:0]        r_tag, n_tag;
    logic [31:0]        r_content, n_content;
    logic [31:0]        r_entries, n_entries;
    logic [PAL_W-1:0]   r_pal_pos, n_pal_pos;
    logic [1:0]         r_size_field, n_size_field;
    logic               r_size_seen, n_size_seen;
    logic               r_voxels_seen, n_voxels_seen;
    logic [2:0]         r_fault, n_fault;
    logic               r_overrun, n_overrun;
    logic [31:0]        r_held_x, n_held_x;
    logic [31:0]        r_held_y, n_held_y;

    logic [31:0]        w;
    logic               full;
    logic               in_content;

    // where a chunk goes once its fixed layout is read
    function automatic t_phase finish_phase(input logic ovr, input logic [31:0] rem);
        t_phase ph;
        if (ovr) begin
            ph = PH_HALT;
        end else if (rem == 32'd0) begin
            ph = PH_CHUNK_TAG;
        end else begin
            ph = PH_SKIP;
        end
        return ph;
    endfunction

    assign w    = {i_data_byte, r_word[31:8]};
    assign full = (r_byte_pos == 2'd3);
    assign in_content = (r_phase == PH_SIZE_DATA) || (r_phase == PH_XYZI_COUNT) ||
                        (r_phase == PH_XYZI_ENTRIES) || (r_phase == PH_RGBA);

    always_comb begin
        n_phase       = r_phase;
        n_byte_pos    = r_byte_pos;
        n_word        = r_word;
        n_tag         = r_tag;
        n_content     = r_content;
        n_entries     = r_entries;
        n_pal_pos     = r_pal_pos;
        n_size_field  = r_size_field;
        n_size_seen   = r_size_seen;
        n_voxels_seen = r_voxels_seen;
        n_fault       = r_fault;
        n_overrun     = r_overrun;
        n_held_x      = r_held_x;
        n_held_y      = r_held_y;
        o_data_rec    = '0;
        o_done_rec    = '0;
        o_push        = '0;

        if (i_take) begin
            if (r_phase != PH_HALT && r_phase != PH_SKIP) begin
                n_word     = w;
                n_byte_pos = r_byte_pos + 2'd1;
                if (in_content) begin
                    if (r_content == 32'd0) begin
                        n_overrun = 1'b1;
                    end else begin
                        n_content = r_content - 32'd1;
                    end
                end
                if (full) begin
                    unique case (r_phase)
                        PH_MAGIC: begin
                            if (w != vcsp_pkg::TAG_VOX) begin
                                n_fault = vcsp_pkg::STATUS_BAD_MAGIC;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase = PH_VERSION;
                            end
                        end
                        PH_VERSION:       n_phase = PH_MAIN_TAG;
                        PH_MAIN_TAG: begin
                            if (w != vcsp_pkg::TAG_MAIN) begin
                                n_fault = vcsp_pkg::STATUS_BAD_MAIN;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase = PH_MAIN_CONTENT;
                            end
                        end
                        PH_MAIN_CONTENT:  n_phase = PH_MAIN_CHILDREN;
                        PH_MAIN_CHILDREN: n_phase = PH_CHUNK_TAG;
                        PH_CHUNK_TAG: begin
                            n_tag   = w;
                            n_phase = PH_CHUNK_CSIZE;
                        end
                        PH_CHUNK_CSIZE: begin
                            n_content = w;
                            n_phase   = PH_CHUNK_KSIZE;
                        end
                        PH_CHUNK_KSIZE: begin
                            // negative content size stops chunk parsing
                            if (r_content[31]) begin
                                n_phase = PH_HALT;
                            end else begin
                                n_overrun = 1'b0;
                                if (r_tag == vcsp_pkg::TAG_SIZE) begin
                                    n_size_seen  = 1'b1;
                                    n_size_field = 2'd0;
                                    n_phase      = PH_SIZE_DATA;
                                end else if (r_tag == vcsp_pkg::TAG_XYZI && !r_voxels_seen) begin
                                    n_voxels_seen = 1'b1;
                                    n_phase       = PH_XYZI_COUNT;
                                end else if (r_tag == vcsp_pkg::TAG_RGBA) begin
                                    n_pal_pos = '0;
                                    n_phase   = PH_RGBA;
                                end else begin
                                    n_phase = finish_phase(1'b0, r_content);
                                end
                            end
                        end
                        PH_SIZE_DATA: begin
                            if (r_size_field == 2'd0) begin
                                n_held_x = w;
                            end else if (r_size_field == 2'd1) begin
                                n_held_y = w;
                            end else begin
                                o_push.data_push       = 1'b1;
                                o_data_rec.record_kind = vcsp_pkg::KIND_SIZE;
                                o_data_rec.extent_x    = r_held_x;
                                o_data_rec.extent_y    = r_held_y;
                                o_data_rec.extent_z    = w;
                                n_phase = finish_phase(n_overrun, n_content);
                            end
                            n_size_field = r_size_field + 2'd1;
                        end
                        PH_XYZI_COUNT: begin
                            if (w != 32'd0 && !w[31]) begin
                                n_entries = w;
                                n_phase   = PH_XYZI_ENTRIES;
                            end else begin
                                n_phase = finish_phase(n_overrun, n_content);
                            end
                        end
                        PH_XYZI_ENTRIES: begin
                            o_push.data_push       = 1'b1;
                            o_data_rec.record_kind = vcsp_pkg::KIND_VOXEL;
                            o_data_rec.voxel_x     = w[7:0];
                            o_data_rec.voxel_y     = w[15:8];
                            o_data_rec.voxel_z     = w[23:16];
                            o_data_rec.color_slot  = w[31:24];
                            n_entries = r_entries - 32'd1;
                            if (n_entries == 32'd0) begin
                                n_phase = finish_phase(n_overrun, n_content);
                            end
                        end
                        PH_RGBA: begin
                            o_push.data_push         = 1'b1;
                            o_data_rec.record_kind   = vcsp_pkg::KIND_PALETTE;
                            o_data_rec.palette_index = 8'(r_pal_pos);
                            o_data_rec.rgba_word     = {w[7:0], w[15:8], w[23:16], w[31:24]};
                            n_pal_pos = r_pal_pos + PAL_W'(1);
                            if (n_pal_pos == PAL_LAST) begin
                                n_phase = finish_phase(n_overrun, n_content);
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (r_phase == PH_SKIP) begin
                if (r_content != 32'd0) begin
                    n_content = r_content - 32'd1;
                end
                if (n_content == 32'd0) begin
                    n_phase = PH_CHUNK_TAG;
                end
            end

            if (i_end_of_file) begin
                o_push.done_push       = 1'b1;
                o_done_rec.record_kind = vcsp_pkg::KIND_DONE;
                if (n_fault != vcsp_pkg::STATUS_OK) begin
                    o_done_rec.status = n_fault;
                end else if (n_phase == PH_MAGIC) begin
                    o_done_rec.status = vcsp_pkg::STATUS_BAD_MAGIC;
                end else if (n_phase == PH_VERSION || n_phase == PH_MAIN_TAG) begin
                    o_done_rec.status = vcsp_pkg::STATUS_BAD_MAIN;
                end else if (!n_size_seen) begin
                    o_done_rec.status = vcsp_pkg::STATUS_NO_SIZE;
                end else if (!n_voxels_seen) begin
                    o_done_rec.status = vcsp_pkg::STATUS_NO_VOXELS;
                end else begin
                    o_done_rec.status = vcsp_pkg::STATUS_OK;
                end
                // the next byte starts a new file
                n_phase       = PH_MAGIC;
                n_byte_pos    = '0;
                n_word        = '0;
                n_tag         = '0;
                n_content     = '0;
                n_entries     = '0;
                n_pal_pos     = '0;
                n_size_field  = '0;
                n_size_seen   = 1'b0;
                n_voxels_seen = 1'b0;
                n_fault       = '0;
                n_overrun     = 1'b0;
                n_held_x      = '0;
                n_held_y      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_byte_pos    <= '0;
            r_word        <= '0;
            r_tag         <= '0;
            r_content     <= '0;
            r_entries     <= '0;
            r_pal_pos     <= '0;
            r_size_field  <= '0;
            r_size_seen   <= 1'b0;
            r_voxels_seen <= 1'b0;
            r_fault       <= '0;
            r_overrun     <= 1'b0;
            r_held_x      <= '0;
            r_held_y      <= '0;
        end else begin
            r_phase       <= n_phase;
            r_byte_pos    <= n_byte_pos;
            r_word        <= n_word;
            r_tag         <= n_tag;
            r_content     <= n_content;
            r_entries     <= n_entries;
            r_pal_pos     <= n_pal_pos;
            r_size_field  <= n_size_field;
            r_size_seen   <= n_size_seen;
            r_voxels_seen <= n_voxels_seen;
            r_fault       <= n_fault;
            r_overrun     <= n_overrun;
            r_held_x      <= n_held_x;
            r_held_y      <= n_held_y;
        end
    end

endmodule

// File: sv/vcsp_queue.sv
module vcsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vcsp_pkg::t_push   i_push,
    input  vcsp_pkg::t_record i_data_rec,
    input  vcsp_pkg::t_record i_done_rec,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output vcsp_pkg::t_record o_head
);

    localparam int PW = vcsp_pkg::QUEUE_PTR_W;
    localparam int CW = vcsp_pkg::QUEUE_CNT_W;

    vcsp_pkg::t_record r_mem [vcsp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_head, n_head;
    logic [PW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [1:0]        push_cnt;
    logic              pop;

    assign push_cnt = {1'b0, i_push.data_push} + {1'b0, i_push.done_push};
    assign pop      = i_pop && o_valid;
    assign o_valid  = (r_count != '0);
    // accept a byte only with room for both records it may cause
    assign o_room   = (r_count <= CW'(vcsp_pkg::QUEUE_DEPTH - 2));
    assign o_head   = r_mem[r_head];

    always_comb begin
        n_tail  = r_tail + PW'(push_cnt);
        n_head  = r_head + PW'(pop);
        n_count = r_count + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.data_push) begin
            r_mem[r_tail] <= i_data_rec;
        end else if (i_push.done_push) begin
            r_mem[r_tail] <= i_done_rec;
        end
        if (i_push.data_push && i_push.done_push) begin
            r_mem[r_tail + PW'(1)] <= i_done_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule
